[rtl/kmnc_pkg.sv]
// kmnc_pkg: shared constants, types and state codes for the k-means core.
// No dependencies.
package kmnc_pkg;
  localparam int MAX_CENTERS = 16;
  localparam int MAX_DIM     = 16;
  localparam int COORD_WIDTH = 16;
  localparam int CW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int DW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SUM_W = 36;
  localparam int CNT_W = 20;
  localparam int DIST_W = 38;
  localparam int SUMS_DEPTH = MAX_CENTERS * MAX_DIM;
  localparam int SA_W = CW + DW;
  localparam logic [4:0] NO_CENTER_CODE = 5'd16;
  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_ASSIGN = 1'b1;
  localparam logic CFG_CENTERS = 1'b0;
  localparam logic CFG_DIMS = 1'b1;

  typedef struct packed {
    logic                          cmd;
    logic signed [COORD_WIDTH-1:0] coord;
    logic                          last;
    logic [4:0]                    given_center;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]        center;
    logic [DIST_W-1:0] sq_distance;
    logic              moved;
    logic              no_center;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SRCH_RD, S_SRCH_DIV, S_SRCH_ACC, S_DECIDE,
    S_UPD_RD, S_UPD_WR, S_OUT, S_CAND_END, S_MOVE
  } state_t;

  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic capture;
    logic srch_init;
    logic rd_sum;
    logic div_start;
    logic acc_step;
    logic cand_done;
    logic upd_init;
    logic upd_rd;
    logic upd_wr;
    logic upd_sel_new;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_busy;
    logic point_done;
    logic seed_ok;
    logic is_assign;
    logic cand_empty;
    logic dim_last;
    logic cand_last;
    logic found;
    logic do_remove;
    logic do_add;
    logic upd_dim_last;
  } stat_t;
endpackage

[rtl/kmnc_ram.sv]
// kmnc_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
module kmnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/kmnc_div.sv]
// kmnc_div: iterative restoring divider, one quotient bit per cycle.
// Depends on kmnc_pkg.
module kmnc_div import kmnc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W:0]   dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             busy,
  output logic [SUM_W:0]   quotient
);
  localparam int NW = SUM_W + 1;
  localparam int KW = $clog2(NW + 1);
  logic [NW-1:0]  q_r, q_nxt;
  logic [CNT_W:0] rem_r, rem_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic           busy_r, busy_nxt;
  logic [CNT_W:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; k_nxt = k_r; busy_nxt = busy_r;
    trial = {rem_r[CNT_W-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; k_nxt = KW'(NW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      k_nxt = k_r - 1'b1;
      if (k_r == KW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
    q_r <= q_nxt; rem_r <= rem_nxt; k_r <= k_nxt;
  end
  assign busy = busy_r;
  assign quotient = q_r;
endmodule

[rtl/kmnc_datapath.sv]
// kmnc_datapath: point buffer, center tables, distance and update arithmetic.
// Depends on kmnc_pkg, kmnc_ram, kmnc_div.
module kmnc_datapath import kmnc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output stat_t      stat,
  input  in_beat_t   in_beat,
  input  logic [4:0] centers_used,
  input  logic [4:0] dims_used,
  output out_beat_t  out_beat
);
  localparam int PW = $clog2(MAX_DIM + 1);
  localparam int CNW = $clog2(MAX_CENTERS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [DIST_W-1:0] DMAX = '1;

  logic [CNW-1:0] nc;
  logic [PW-1:0]  nd;
  always_comb begin
    if (centers_used == 5'd0) nc = CNW'(1);
    else if (32'(centers_used) > MAX_CENTERS) nc = CNW'(MAX_CENTERS);
    else nc = CNW'(centers_used);
    if (dims_used == 5'd0) nd = PW'(1);
    else if (32'(dims_used) > MAX_DIM) nd = PW'(MAX_DIM);
    else nd = PW'(dims_used);
  end

  // point buffer, positions beyond the fill read as zero
  logic signed [COORD_WIDTH-1:0] pbuf_r [MAX_DIM];
  logic [PW-1:0] pos_r, fill_r;
  logic cmd_r;
  logic [4:0] given_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.capture) begin
      if (in_beat.last) pos_r <= '0;
      else if (pos_r < nd) pos_r <= pos_r + 1'b1;
    end
    if (cmd.capture) begin
      if (pos_r < nd) pbuf_r[pos_r[DW-1:0]] <= in_beat.coord;
      if (in_beat.last) begin
        fill_r <= (pos_r < nd) ? pos_r + 1'b1 : pos_r;
        cmd_r <= in_beat.cmd;
        given_r <= in_beat.given_center;
      end
    end
  end

  // member counts, zero after reset
  logic [CNT_W-1:0] cnt_r [MAX_CENTERS];

  // indices
  logic [CW-1:0] c_r, best_r;
  logic [DW-1:0] d_r;
  logic [CNT_W-1:0] n_r;
  logic signed [COORD_WIDTH-1:0] x_d;
  assign x_d = (PW'(d_r) < fill_r) ? pbuf_r[d_r] : '0;

  // sums memory plus clear sweep
  logic [SA_W-1:0] clr_r;
  logic clr_done_r;
  logic we;
  logic [SA_W-1:0] waddr, raddr;
  logic [SUM_W-1:0] wdata, rdata;
  logic [CW-1:0] uc_r;
  logic upd_new_r;
  // update sweep reads its own center in the cycle before the write back
  assign raddr = cmd.upd_rd ? {uc_r, d_r} : {c_r, d_r};

  kmnc_ram #(.WIDTH(SUM_W), .DEPTH(SUMS_DEPTH)) u_sums (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // divider for rounded mean
  logic sneg_r;
  logic [SUM_W:0] mag;
  logic [SUM_W:0] quo;
  logic dbusy;
  assign mag = rdata[SUM_W-1] ? ({1'b0, ~rdata} + 1'b1) : {1'b0, rdata};
  kmnc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(mag + (SUM_W+1)'(n_r >> 1)), .divisor(n_r),
    .busy(dbusy), .quotient(quo)
  );

  // clamp mean, difference, square
  localparam logic [SUM_W:0] HI = (SUM_W+1)'((64'd1 << (COORD_WIDTH-1)) - 1);
  logic signed [COORD_WIDTH-1:0] mean;
  logic signed [COORD_WIDTH+1:0] diff;
  logic [COORD_WIDTH:0] dmag;
  logic [2*COORD_WIDTH+1:0] sq;
  logic [DIST_W:0] acc_sum;
  logic [DIST_W-1:0] acc_r, bestd_r;
  logic sat_r, found_r;
  always_comb begin
    if (sneg_r) mean = (quo > HI) ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                  : -$signed(COORD_WIDTH'(quo));
    else mean = (quo > HI) ? $signed(COORD_WIDTH'(HI)) : $signed(COORD_WIDTH'(quo));
    diff = (COORD_WIDTH+2)'(x_d) - (COORD_WIDTH+2)'(mean);
    dmag = diff[COORD_WIDTH+1] ? (COORD_WIDTH+1)'(-diff) : (COORD_WIDTH+1)'(diff);
    sq = (2*COORD_WIDTH+2)'(dmag) * (2*COORD_WIDTH+2)'(dmag);
    acc_sum = (DIST_W+1)'(acc_r) + (DIST_W+1)'(sq);
  end

  logic [DIST_W-1:0] dfin;
  assign dfin = sat_r ? DMAX : acc_r;
  logic has_prev;
  assign has_prev = (given_r != NO_CENTER_CODE) && (32'(given_r) < MAX_CENTERS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0; clr_done_r <= 1'b0;
      for (int i = 0; i < MAX_CENTERS; i++) cnt_r[i] <= '0;
    end else begin
      if (cmd.clr_start) begin clr_r <= '0; clr_done_r <= 1'b0; end
      else if (cmd.clr_step) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == SA_W'(SUMS_DEPTH - 1)) clr_done_r <= 1'b1;
      end
      if (cmd.upd_wr && stat.upd_dim_last) begin
        if (upd_new_r) cnt_r[uc_r] <= cnt_r[uc_r] + 1'b1;
        else cnt_r[uc_r] <= cnt_r[uc_r] - 1'b1;
      end
    end
    if (cmd.srch_init) begin
      c_r <= '0; d_r <= '0; acc_r <= '0; sat_r <= 1'b0; found_r <= 1'b0;
      bestd_r <= '0; best_r <= '0; n_r <= cnt_r[0];
    end
    if (cmd.rd_sum) sneg_r <= rdata[SUM_W-1];
    if (cmd.acc_step) begin
      if (acc_sum > (DIST_W+1)'(DMAX)) sat_r <= 1'b1;
      acc_r <= acc_sum[DIST_W-1:0];
      d_r <= d_r + 1'b1;
    end
    if (cmd.cand_done) begin
      if (!stat.cand_empty && (!found_r || dfin < bestd_r)) begin
        found_r <= 1'b1; best_r <= c_r; bestd_r <= dfin;
      end
      c_r <= c_r + 1'b1; d_r <= '0; acc_r <= '0; sat_r <= 1'b0;
      n_r <= cnt_r[CW'(c_r + 1'b1)];
    end
    if (cmd.upd_init) begin
      d_r <= '0;
      upd_new_r <= cmd.upd_sel_new;
      if (cmd.upd_sel_new) uc_r <= (cmd_r == CMD_SEED) ? given_r[CW-1:0] : best_r;
      else uc_r <= given_r[CW-1:0];
    end else if (cmd.upd_wr) d_r <= d_r + 1'b1;
    if (cmd.out_load) begin
      out_beat.center <= 4'((cmd_r == CMD_SEED) ? CW'(given_r) : (found_r ? best_r : '0));
      out_beat.sq_distance <= (cmd_r == CMD_SEED || !found_r) ? '0 : bestd_r;
      out_beat.moved <= (cmd_r == CMD_ASSIGN) && found_r && (!has_prev || CW'(given_r) != best_r);
      out_beat.no_center <= (cmd_r == CMD_ASSIGN) && !found_r;
    end
  end

  always_comb begin
    we = 1'b0; waddr = {uc_r, d_r}; wdata = '0;
    if (cmd.clr_step) begin we = 1'b1; waddr = clr_r; end
    else if (cmd.upd_wr) begin
      we = 1'b1;
      wdata = upd_new_r ? rdata + SUM_W'(x_d) : rdata - SUM_W'(x_d);
    end
  end

  always_comb begin
    stat = '0;
    stat.clr_done = clr_done_r;
    stat.div_busy = dbusy;
    stat.point_done = in_beat.last;
    stat.seed_ok = (given_r != NO_CENTER_CODE) && ({1'b0, given_r} < 6'(nc));
    stat.is_assign = cmd_r == CMD_ASSIGN;
    stat.cand_empty = n_r == '0;
    stat.dim_last = PW'(d_r) == nd - 1'b1;
    stat.cand_last = CNW'(c_r) == nc - 1'b1;
    stat.found = found_r;
    stat.do_remove = has_prev && CW'(given_r) != best_r && cnt_r[given_r[CW-1:0]] != '0;
    stat.do_add = (cmd_r == CMD_SEED)
                  ? cnt_r[given_r[CW-1:0]] != CNT_MAX
                  : (!has_prev || CW'(given_r) != best_r) && cnt_r[best_r] != CNT_MAX;
    stat.upd_dim_last = PW'(d_r) == nd - 1'b1;
  end
endmodule

[rtl/kmnc_ctrl.sv]
// kmnc_ctrl: sequencer for capture, clear sweep, search and table update.
// Depends on kmnc_pkg.
module kmnc_ctrl import kmnc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state_r, state_nxt;
  logic   rm_pend_r, rm_pend_nxt;
  logic   clr_go_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; rm_pend_r <= 1'b0; clr_go_r <= 1'b1;
    end else begin
      state_r <= state_nxt; rm_pend_r <= rm_pend_nxt; clr_go_r <= 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r; rm_pend_nxt = rm_pend_r; cmd = '0;
    in_ready = 1'b0; out_valid = 1'b0;
    case (state_r)
      S_CLEAR: begin
        if (clr_go_r) cmd.clr_start = 1'b1;
        else if (stat.clr_done) state_nxt = S_IDLE;
        else cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (stat.point_done) state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // first pass here after capture: pick seed or search
        if (!stat.is_assign) begin
          if (!stat.seed_ok) state_nxt = S_IDLE;
          else if (stat.do_add) begin
            cmd.upd_init = 1'b1; cmd.upd_sel_new = 1'b1; state_nxt = S_UPD_RD;
          end else begin
            cmd.out_load = 1'b1; state_nxt = S_OUT;
          end
        end else begin
          cmd.srch_init = 1'b1; state_nxt = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (stat.cand_empty) begin
          cmd.cand_done = 1'b1;
          if (stat.cand_last) state_nxt = S_MOVE;
        end else state_nxt = S_SRCH_DIV;
      end
      S_SRCH_DIV: begin
        cmd.rd_sum = 1'b1; cmd.div_start = 1'b1; state_nxt = S_SRCH_ACC;
      end
      S_SRCH_ACC: begin
        if (!stat.div_busy) begin
          cmd.acc_step = 1'b1;
          if (stat.dim_last) state_nxt = S_CAND_END;
          else state_nxt = S_SRCH_RD;
        end
      end
      S_CAND_END: begin
        // distance of this candidate is complete
        cmd.cand_done = 1'b1;
        state_nxt = stat.cand_last ? S_MOVE : S_SRCH_RD;
      end
      S_MOVE: begin
        // search finished: start moves, or load the result if none is needed
        if (!stat.found) begin cmd.out_load = 1'b1; state_nxt = S_OUT; end
        else if (stat.do_remove) begin
          cmd.upd_init = 1'b1; rm_pend_nxt = 1'b1; state_nxt = S_UPD_RD;
        end else if (stat.do_add) begin
          cmd.upd_init = 1'b1; cmd.upd_sel_new = 1'b1; state_nxt = S_UPD_RD;
        end else begin cmd.out_load = 1'b1; state_nxt = S_OUT; end
      end
      S_UPD_RD: begin
        // read slot for the sum being updated
        cmd.upd_rd = 1'b1;
        state_nxt = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        if (!stat.upd_dim_last) state_nxt = S_UPD_RD;
        else if (rm_pend_r && stat.do_add) begin
          rm_pend_nxt = 1'b0; cmd.upd_init = 1'b1; cmd.upd_sel_new = 1'b1;
          state_nxt = S_UPD_RD;
        end else begin
          rm_pend_nxt = 1'b0; cmd.out_load = 1'b1; state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

[rtl/kmeans_nearest_centroid_update_core.sv]
// kmeans_nearest_centroid_update_core: online k-means nearest-centre assignment and update.
// Depends on kmnc_pkg, kmnc_ctrl, kmnc_datapath (and through it kmnc_ram, kmnc_div).
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | in_data  (in_beat_t: cmd, coord, last, given_center)
//  out     | out_valid/ out_ready | out_data (out_beat_t: center, sq_distance, moved, no_center)
//  cfg     | cfg_valid/ cfg_ready | cfg_index (1 bit), cfg_data (5 bits)
//
// Coordinate beats are captured while idle; the last beat leads to a decide step.
// Assign: an empty center is skipped, a filled one is scanned coordinate by
// coordinate (read, divider start, divider steps, accumulate) and then closed;
// then the move is picked and up to two update sweeps over dims_used run.
// A seed skips the search and takes at most one sweep. After reset a clearing
// pass over all MAX_CENTERS*MAX_DIM sum entries zeroes the sums; no beat is
// accepted meanwhile. A held result stalls the input side.
module kmeans_nearest_centroid_update_core import kmnc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [4:0] cfg_data
);
  logic [4:0] centers_used_r, dims_used_r;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centers_used_r <= 5'd16; dims_used_r <= 5'd16;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_CENTERS) centers_used_r <= cfg_data;
      else dims_used_r <= cfg_data;
    end
  end

  kmnc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  kmnc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_beat(in_data),
    .centers_used(centers_used_r), .dims_used(dims_used_r), .out_beat(out_data)
  );
endmodule
